/* hw/rtl/chi_square_caesar_shift_finder_defines.svh */
// Assertion macros shared by the shift finder RTL.
`ifndef CHI_SQUARE_CAESAR_SHIFT_FINDER_DEFINES_SVH
`define CHI_SQUARE_CAESAR_SHIFT_FINDER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define CSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/csf_pkg.sv */
// Types, constants and weight table of the Caesar shift finder.
package csf_pkg;

    localparam int MAX_COLUMN_LEN = 4096;
    localparam int LETTERS        = 26;
    localparam int LETTER_W       = $clog2(LETTERS);
    localparam int COUNT_W        = $clog2(MAX_COLUMN_LEN + 1);
    localparam int SQ_W           = 2 * COUNT_W;
    localparam int WEIGHT_W       = 27;
    localparam int PROD_W         = SQ_W + WEIGHT_W;
    localparam int ACC_W          = PROD_W + LETTER_W;
    localparam int SCORE_W        = 51;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);
    localparam logic [COUNT_W-1:0]  COUNT_MAX   = COUNT_W'(MAX_COLUMN_LEN);
    localparam logic [7:0]          CHAR_A      = 8'h61;
    localparam logic [7:0]          CHAR_Z      = 8'h7A;
    localparam logic [SCORE_W-1:0]  SCORE_MAX   = '1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_Q16 [LETTERS] = '{
        27'd802449,   27'd4392493,  27'd2355715,  27'd1540936,  27'd515950,
        27'd2941472,  27'd3252407,  27'd1075418,  27'd940798,   27'd42833987,
        27'd8489119,  27'd1628224,  27'd2723857,  27'd971048,   27'd872999,
        27'd3397408,  27'd68985263, 27'd1094638,  27'd1035815,  27'd723675,
        27'd2376215,  27'd6701022,  27'd2776949,  27'd43690667, 27'd3319959,
        27'd88562162
    };

    typedef enum logic [1:0] {
        S_COUNT,
        S_SCORE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         best_shift;
        logic [SCORE_W-1:0] best_score;
    } t_out_item;

    typedef struct packed {
        logic                count_en;
        logic                hit;
        logic [LETTER_W-1:0] letter;
        logic                rotate;
        logic                clear;
    } t_cell_ctl;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic                final_term;
        logic [LETTER_W-1:0] shift;
        logic [LETTER_W-1:0] widx;
    } t_issue;

endpackage

/* hw/rtl/csf_cell.sv */
// One letter counter of the rotating count ring.
`include "chi_square_caesar_shift_finder_defines.svh"

module csf_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  csf_pkg::t_cell_ctl           i_ctl,
    input  logic [csf_pkg::LETTER_W-1:0] i_index,
    input  logic [csf_pkg::COUNT_W-1:0]  i_next_count,
    output logic [csf_pkg::COUNT_W-1:0]  o_count
);

    logic [csf_pkg::COUNT_W-1:0] r_count;
    logic [csf_pkg::COUNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        priority if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.rotate) begin
            n_count = i_next_count;
        end else if (i_ctl.count_en && i_ctl.hit && i_ctl.letter == i_index
                     && r_count < csf_pkg::COUNT_MAX) begin
            n_count = r_count + csf_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

    `CSF_ASSERT_NOW(a_count_sat, 1'b1, r_count <= csf_pkg::COUNT_MAX, "count above bound")

endmodule

/* hw/rtl/csf_score.sv */
// Square, weight, accumulate and minimum search over the rotating counts.
`include "chi_square_caesar_shift_finder_defines.svh"

module csf_score (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  csf_pkg::t_issue              i_issue,
    input  logic [csf_pkg::COUNT_W-1:0]  i_head,
    output logic                         o_done,
    output logic [csf_pkg::LETTER_W-1:0] o_best_shift,
    output logic [csf_pkg::ACC_W-1:0]    o_best_score
);

    logic [csf_pkg::SQ_W-1:0]     w_head_ext;
    csf_pkg::t_issue              r_s1;
    csf_pkg::t_issue              r_s2;
    logic [csf_pkg::SQ_W-1:0]     r_sq;
    logic [csf_pkg::PROD_W-1:0]   r_prod;
    logic [csf_pkg::ACC_W-1:0]    r_acc;
    logic [csf_pkg::ACC_W-1:0]    n_acc;
    logic                         r_sum_valid;
    logic                         r_sum_final;
    logic [csf_pkg::LETTER_W-1:0] r_sum_shift;
    logic [csf_pkg::ACC_W-1:0]    r_sum;
    logic [csf_pkg::LETTER_W-1:0] r_best_shift;
    logic [csf_pkg::ACC_W-1:0]    r_best;
    logic                         r_done;
    logic                         w_take;

    assign w_head_ext = csf_pkg::SQ_W'(i_head);
    assign n_acc = (r_s2.first ? '0 : r_acc) + csf_pkg::ACC_W'(r_prod);
    assign w_take = r_sum_valid && (r_sum_shift == '0 || r_sum < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_sum_valid <= 1'b0;
            r_sum_final <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_s1        <= i_issue;
            r_s2        <= r_s1;
            r_sum_valid <= r_s2.valid && r_s2.last;
            r_sum_final <= r_s2.valid && r_s2.final_term;
            r_done      <= r_sum_valid && r_sum_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq   <= w_head_ext * w_head_ext;
        r_prod <= csf_pkg::PROD_W'(r_sq)
                  * csf_pkg::PROD_W'(csf_pkg::WEIGHT_Q16[r_s1.widx]);
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
        if (r_s2.valid && r_s2.last) begin
            r_sum       <= n_acc;
            r_sum_shift <= r_s2.shift;
        end
        if (w_take) begin
            r_best       <= r_sum;
            r_best_shift <= r_sum_shift;
        end
    end

    assign o_done       = r_done;
    assign o_best_shift = r_best_shift;
    assign o_best_score = r_best;

    `CSF_ASSERT_NEXT(a_final_done, r_sum_valid && r_sum_final, r_done, "missing done")

endmodule

/* hw/rtl/chi_square_caesar_shift_finder.sv */
// Top level of the Caesar shift finder for one key column.
// Input channel: i_in_valid, o_in_stall, i_in_item {cipher_byte, last_byte}.
// Output channel: o_out_valid, i_out_stall, o_out_item {best_shift, best_score}.
// An item is taken at a clock edge with valid high and stall low.
// While counting, one cipher byte is taken every cycle; bytes 'a' to 'z'
// bump their letter counter, which stops at 4096.
// The item marked last is counted, then o_in_stall rises while the ring of
// 26 counters rotates once per cycle through one square-weight-accumulate
// unit: 26 shifts of 26 terms, then the pipeline and minimum search drain.
// The result then enters the output register; the counts clear and input
// reopens in that cycle.
// A result waiting under i_out_stall does not block counting of the next
// column; a second column end keeps input stalled until the output register frees.
// best_score saturates at 2^51 - 1. Ties pick the smallest shift.
// Reset (i_rst_n low, synchronous) clears all counts and empties the output.
`include "chi_square_caesar_shift_finder_defines.svh"

module chi_square_caesar_shift_finder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  csf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output csf_pkg::t_out_item o_out_item
);

    csf_pkg::t_state              r_state;
    csf_pkg::t_state              n_state;
    logic [csf_pkg::LETTER_W-1:0] r_shift;
    logic [csf_pkg::LETTER_W-1:0] n_shift;
    logic [csf_pkg::LETTER_W-1:0] r_term;
    logic [csf_pkg::LETTER_W-1:0] n_term;
    logic [csf_pkg::LETTER_W-1:0] r_widx;
    logic [csf_pkg::LETTER_W-1:0] n_widx;
    logic                         r_issuing;
    logic                         n_issuing;
    logic                         r_out_valid;
    logic                         n_out_valid;
    csf_pkg::t_out_item           r_out_item;
    logic                         w_load;
    csf_pkg::t_cell_ctl           w_ctl;
    csf_pkg::t_issue              w_issue;
    logic [csf_pkg::COUNT_W-1:0]  w_count [csf_pkg::LETTERS];
    logic                         w_done;
    logic [csf_pkg::LETTER_W-1:0] w_best_shift;
    logic [csf_pkg::ACC_W-1:0]    w_best_score;
    logic [csf_pkg::SCORE_W-1:0]  w_score_sat;

    for (genvar g = 0; g < csf_pkg::LETTERS; g++) begin : g_cell
        csf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_index      (csf_pkg::LETTER_W'(g)),
            .i_next_count (w_count[(g + 1) % csf_pkg::LETTERS]),
            .o_count      (w_count[g])
        );
    end

    csf_score u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (w_issue),
        .i_head       (w_count[0]),
        .o_done       (w_done),
        .o_best_shift (w_best_shift),
        .o_best_score (w_best_score)
    );

    assign w_score_sat = (w_best_score > csf_pkg::ACC_W'(csf_pkg::SCORE_MAX))
                         ? csf_pkg::SCORE_MAX
                         : csf_pkg::SCORE_W'(w_best_score);

    always_comb begin
        n_state   = r_state;
        n_shift   = r_shift;
        n_term    = r_term;
        n_widx    = r_widx;
        n_issuing = r_issuing;
        w_load    = 1'b0;
        w_ctl.count_en = 1'b0;
        w_ctl.hit      = i_in_item.cipher_byte >= csf_pkg::CHAR_A
                         && i_in_item.cipher_byte <= csf_pkg::CHAR_Z;
        w_ctl.letter   = csf_pkg::LETTER_W'(i_in_item.cipher_byte - csf_pkg::CHAR_A);
        w_ctl.rotate   = 1'b0;
        w_ctl.clear    = 1'b0;
        unique case (r_state)
            csf_pkg::S_COUNT: begin
                if (i_in_valid) begin
                    w_ctl.count_en = 1'b1;
                    if (i_in_item.last_byte) begin
                        n_state   = csf_pkg::S_SCORE;
                        n_shift   = '0;
                        n_term    = '0;
                        n_widx    = '0;
                        n_issuing = 1'b1;
                    end
                end
            end
            csf_pkg::S_SCORE: begin
                if (r_issuing) begin
                    w_ctl.rotate = 1'b1;
                    if (r_term == csf_pkg::LAST_LETTER) begin
                        n_term = '0;
                        if (r_shift == csf_pkg::LAST_LETTER) begin
                            n_issuing = 1'b0;
                        end else begin
                            n_shift = r_shift + csf_pkg::LETTER_W'(1);
                        end
                    end else begin
                        n_term = r_term + csf_pkg::LETTER_W'(1);
                        n_widx = (r_widx == csf_pkg::LAST_LETTER)
                                 ? '0 : r_widx + csf_pkg::LETTER_W'(1);
                    end
                end
                if (w_done) begin
                    n_state = csf_pkg::S_EMIT;
                end
            end
            csf_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    w_ctl.clear = 1'b1;
                    n_state     = csf_pkg::S_COUNT;
                end
            end
            default: begin
                n_state = csf_pkg::S_COUNT;
            end
        endcase
    end

    always_comb begin
        w_issue.valid      = r_state == csf_pkg::S_SCORE && r_issuing;
        w_issue.first      = r_term == '0;
        w_issue.last       = r_term == csf_pkg::LAST_LETTER;
        w_issue.final_term = r_term == csf_pkg::LAST_LETTER
                             && r_shift == csf_pkg::LAST_LETTER;
        w_issue.shift      = r_shift;
        w_issue.widx       = r_widx;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csf_pkg::S_COUNT;
            r_shift     <= '0;
            r_term      <= '0;
            r_widx      <= '0;
            r_issuing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_shift     <= n_shift;
            r_term      <= n_term;
            r_widx      <= n_widx;
            r_issuing   <= n_issuing;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.best_shift <= w_best_shift;
            r_out_item.best_score <= w_score_sat;
        end
    end

    assign o_in_stall  = r_state != csf_pkg::S_COUNT;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `CSF_ASSERT_NOW(a_done_in_score, w_done, r_state == csf_pkg::S_SCORE, "done outside scoring")
    `CSF_ASSERT_NEXT(a_out_from_emit, !r_out_valid && r_state != csf_pkg::S_EMIT, !r_out_valid, "result without scoring")
    `CSF_ASSERT_NEXT(a_clear_on_load, w_load, w_count[0] == '0 && r_state == csf_pkg::S_COUNT, "counts not cleared")

endmodule
